### hw/rtl/jsu_pkg.sv
// Shared types, constants and helpers of the JSON string unescaper.
`default_nettype none

package jsu_pkg;

  localparam int unsigned JSU_QUEUE_DEPTH = 4;
  localparam int unsigned JSU_MAX_CHARS   = 5;
  localparam logic [15:0] JSU_CAP_RESET   = 16'd256;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [15:0] CP_PRINT_LO = 16'd32;
  localparam logic [15:0] CP_PRINT_HI = 16'd126;
  localparam logic [15:0] CP_RSQUO    = 16'h2019;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_HEX    = 3'b100
  } jsu_mode_t;

  // One job: the results caused by one input byte, characters first.
  typedef struct packed {
    logic [JSU_MAX_CHARS-1:0][7:0] chars;
    logic [2:0]                    nchars;
    logic                          term;
  } jsu_job_t;

  // Bit 4 is the valid flag, bits 3:0 the digit value.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/jsu_front.sv
// Front end: takes bytes, tracks parser state and builds one job per byte.
`default_nettype none

module jsu_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [15:0]      cfg_data,
  input  wire logic             take,
  input  wire logic             start_req,
  input  wire logic [7:0]       in_byte,
  output jsu_pkg::jsu_job_t     job,
  output logic                  job_valid
);
  import jsu_pkg::*;

  logic [15:0]      cap;
  jsu_mode_t        mode, mode_next;
  logic [2:0][7:0]  held, held_next;
  logic [1:0]       hex_count, hex_count_next;
  logic [15:0]      emitted, emitted_next;
  logic             finished, finished_next;

  jsu_mode_t        mode_eff;
  logic [2:0][7:0]  held_eff;
  logic [1:0]       hc_eff;
  logic [15:0]      emitted_eff;
  logic             fin_eff;
  logic             full;
  logic [15:0]      room;
  logic [2:0]       nc;
  logic [2:0]       keep;
  logic             term;
  logic [JSU_MAX_CHARS-1:0][7:0] chars;
  logic             nb_term, nb_esc;
  logic [7:0]       nb_char;
  logic [4:0]       hv_b;
  logic [4:0]       hv_h0, hv_h1, hv_h2;
  logic [15:0]      code;
  logic [7:0]       code_char;

  always_comb begin
    mode_eff    = start_req ? MODE_NORMAL : mode;
    held_eff    = start_req ? '0 : held;
    hc_eff      = start_req ? 2'd0 : hex_count;
    emitted_eff = start_req ? 16'd0 : emitted;
    fin_eff     = start_req ? 1'b0 : finished;

    full = ({1'b0, emitted_eff} + 17'd1) >= {1'b0, cap};
    room = full ? 16'd0 : (cap - 16'd1 - emitted_eff);

    nb_term = (in_byte == CH_NUL) || (in_byte == CH_QUOTE);
    nb_esc  = (in_byte == CH_BSLASH);
    nb_char = in_byte[7] ? CH_SPACE : in_byte;

    hv_b  = hex_val(in_byte);
    hv_h0 = hex_val(held_eff[0]);
    hv_h1 = hex_val(held_eff[1]);
    hv_h2 = hex_val(held_eff[2]);
    code  = {hv_h0[3:0], hv_h1[3:0], hv_h2[3:0], hv_b[3:0]};
    if (code >= CP_PRINT_LO && code <= CP_PRINT_HI) begin
      code_char = code[7:0];
    end else if (code == CP_RSQUO) begin
      code_char = CH_APOS;
    end else begin
      code_char = CH_SPACE;
    end

    mode_next      = mode_eff;
    held_next      = held_eff;
    hex_count_next = hc_eff;
    finished_next  = fin_eff;
    chars          = '0;
    nc             = 3'd0;
    term           = 1'b0;

    if (!fin_eff) begin
      if (full) begin
        term = 1'b1;
      end else begin
        unique case (mode_eff)
          MODE_ESCAPE: begin
            mode_next = MODE_NORMAL;
            if (in_byte == CH_U) begin
              mode_next      = MODE_HEX;
              hex_count_next = 2'd0;
            end else if (in_byte == CH_N || in_byte == CH_R || in_byte == CH_T) begin
              chars[0] = CH_SPACE;
              nc       = 3'd1;
            end else if (in_byte == CH_NUL) begin
              term = 1'b1;
            end else begin
              chars[0] = in_byte;
              nc       = 3'd1;
            end
          end
          MODE_HEX: begin
            if (hv_b[4]) begin
              if (hc_eff != 2'd3) begin
                held_next[hc_eff] = in_byte;
                hex_count_next    = hc_eff + 2'd1;
              end else begin
                mode_next      = MODE_NORMAL;
                hex_count_next = 2'd0;
                chars[0]       = code_char;
                nc             = 3'd1;
              end
            end else begin
              // Broken escape: replay 'u' and the digits held, then the byte as normal.
              mode_next      = MODE_NORMAL;
              hex_count_next = 2'd0;
              chars[0]       = CH_U;
              chars[1]       = held_eff[0];
              chars[2]       = held_eff[1];
              chars[3]       = held_eff[2];
              nc             = 3'd1 + {1'b0, hc_eff};
              if (nb_term) begin
                term = 1'b1;
              end else if (nb_esc) begin
                mode_next = MODE_ESCAPE;
              end else begin
                chars[nc] = nb_char;
                nc        = nc + 3'd1;
              end
            end
          end
          default: begin
            mode_next = MODE_NORMAL;
            if (nb_term) begin
              term = 1'b1;
            end else if (nb_esc) begin
              mode_next = MODE_ESCAPE;
            end else begin
              chars[0] = nb_char;
              nc       = 3'd1;
            end
          end
        endcase
      end
      if (term) begin
        finished_next  = 1'b1;
        mode_next      = MODE_NORMAL;
        hex_count_next = 2'd0;
      end
    end

    // Drop the characters beyond the remaining room.
    keep         = (room < {13'd0, nc}) ? room[2:0] : nc;
    emitted_next = emitted_eff + {13'd0, keep};

    job.chars  = chars;
    job.nchars = keep;
    job.term   = term;
    job_valid  = (keep != 3'd0) || term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= JSU_CAP_RESET;
      mode      <= MODE_NORMAL;
      held      <= '0;
      hex_count <= 2'd0;
      emitted   <= 16'd0;
      finished  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_data;
      end
      if (take) begin
        mode      <= mode_next;
        held      <= held_next;
        hex_count <= hex_count_next;
        emitted   <= emitted_next;
        finished  <= finished_next;
      end
    end
  end

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    finished |-> (mode == MODE_NORMAL && hex_count == 2'd0))
    else $error("finished with parser mid-escape");

  a_job_fits: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> ({1'b0, job.nchars} + {3'd0, job.term}) <= 4'd5)
    else $error("job holds more than five results");

endmodule

`default_nettype wire

### hw/rtl/jsu_queue.sv
// Job queue between the front end and the output serialiser.
`default_nettype none

module jsu_queue #(
  parameter int unsigned Depth = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  jsu_pkg::jsu_job_t      push_job,
  output logic                   full,
  input  wire logic              pop,
  output jsu_pkg::jsu_job_t      head,
  output logic                   head_valid
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jsu_job_t          slots [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push, do_pop;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

### hw/rtl/jsu_back.sv
// Back end: walks each queued job and sends its results one beat at a time.
`default_nettype none

module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  jsu_pkg::jsu_job_t  head,
  input  wire logic          head_valid,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata,
  output logic               m_tuser,
  output logic               m_tlast
);
  import jsu_pkg::*;

  logic [2:0] idx;
  logic [2:0] total;
  logic       load;
  logic       is_char;
  logic       cur_last;
  logic [7:0] cur_ch;

  always_comb begin
    total    = head.nchars + {2'd0, head.term};
    is_char  = idx < head.nchars;
    cur_ch   = is_char ? head.chars[idx] : CH_NUL;
    cur_last = (idx == total - 3'd1);
    load     = head_valid && (!m_tvalid || m_tready);
    pop      = load && cur_last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= cur_ch;
      m_tuser <= !is_char;
      m_tlast <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= 3'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= cur_last ? 3'd0 : idx + 3'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (idx < total))
    else $error("serialiser index past end of job");

  a_term_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == CH_NUL))
    else $error("terminator beat not last or not zero");

endmodule

`default_nettype wire

### hw/rtl/json_string_unescaper_top.sv
// Top level of the JSON string unescaper: front end, job queue and serialiser.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tdata: in_byte; tuser: start_req
//  m_       | out       | m_tvalid/m_tready  | tdata: out_byte; tuser: is_terminator;
//           |           |                    | tlast: last_of_run
//  cfg_     | in        | cfg_we             | cfg_data: out_capacity
//
// The front end takes one byte per cycle while the job queue has room, and
// decides in that cycle every result the byte causes (up to five). The
// serialiser sends one beat per cycle from its output register while m_tready
// is high, so a byte costs as many output beats as it has results: one in the
// usual case, up to five when a broken \u escape is replayed. Bytes that give
// no result (backslash, hex digits being collected, input after the
// terminator) take no output beat at all.
// Reset (rst, synchronous) clears the parser, the queue and the output valid
// flag and sets out_capacity to 256; no clearing pass follows.
// A stall on m_tready fills the queue first; s_tready drops only when all
// QueueDepth entries are taken.
`default_nettype none

module json_string_unescaper_top #(
  parameter int unsigned QueueDepth = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,   // out_capacity
  // byte input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // [7:0] in_byte
  input  wire logic        s_tuser,    // [0] start_req
  // result output
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,    // [7:0] out_byte
  output logic             m_tuser,    // [0] is_terminator
  output logic             m_tlast     // last result of this input beat
);
  import jsu_pkg::*;

  jsu_job_t job;
  logic     job_valid;
  logic     take;
  logic     q_full;
  jsu_job_t head;
  logic     head_valid;
  logic     pop;

  // Accept a beat whenever the queue can hold whatever job it makes.
  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .take      (take),
    .start_req (s_tuser),
    .in_byte   (s_tdata),
    .job       (job),
    .job_valid (job_valid)
  );

  // Hold jobs with at least one result; empty jobs are not queued.
  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take && job_valid),
    .push_job   (job),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire
